// File: src/lpmf_pkg.sv
package lpmf_pkg;

	localparam int SLOT_COUNT = 8;
	localparam int FIRST_SLOT = 1;
	localparam int FRAME_BITS = 24;

	// Stored frame counts never exceed the 24-bit input fields.
	localparam int FRAME_W = (FRAME_BITS < 24) ? FRAME_BITS : 24;
	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	localparam int VOL_W = 9;
	localparam int VOL_UNITY = 256;
	localparam int GAIN_W = VOL_W;
	localparam int NUM_W = FRAME_W + VOL_W;
	localparam int CNT_W = $clog2(GAIN_W);
	localparam int PROD_W = 16 + GAIN_W + 1;
	localparam int SUM_W = PROD_W + 1;
	localparam int GAIN_SHIFT = 8;
	localparam int SAMPLE_MAX = 32767;
	localparam int SAMPLE_MIN = -32768;

	typedef enum logic [1:0] {
		OP_REGISTER = 2'd0,
		OP_PLAY     = 2'd1,
		OP_STOP     = 2'd2,
		OP_MIX      = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_MUL,
		S_DIV,
		S_SCALE,
		S_MIX,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic [7:0]         slot;
		logic [23:0]        song_frames;
		logic [23:0]        loop_frame;
		logic [23:0]        fade_len;
		logic signed [15:0] mix_left;
		logic signed [15:0] mix_right;
		logic signed [15:0] song_left;
		logic signed [15:0] song_right;
	} cmd_t;

	typedef struct packed {
		logic               accepted;
		logic signed [15:0] out_left;
		logic signed [15:0] out_right;
		logic               is_playing;
		logic [7:0]         active_slot;
		logic [23:0]        cursor;
	} rsp_t;

	typedef struct packed {
		logic [FRAME_W-1:0] len;
		logic [FRAME_W-1:0] loop;
	} slot_ent_t;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] idx;
	} slot_lk_t;

	function automatic slot_lk_t slot_lookup(input logic [7:0] s);
		logic [8:0] d;
		slot_lk_t   r;
		d = {1'b0, s} - 9'(FIRST_SLOT);
		r.hit = ({1'b0, s} >= 9'(FIRST_SLOT)) && (d < 9'(SLOT_COUNT));
		r.idx = d[IDX_W-1:0];
		return r;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [SUM_W-1:0] v);
		logic signed [15:0] r;
		if (v > SUM_W'(SAMPLE_MAX))
			r = 16'(SAMPLE_MAX);
		else if (v < SUM_W'(SAMPLE_MIN))
			r = 16'(SAMPLE_MIN);
		else
			r = v[15:0];
		return r;
	endfunction

endpackage

// File: src/lpmf_if.sv
interface lpmf_cmd_if import lpmf_pkg::*; ();
	logic valid;
	logic ready;
	cmd_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lpmf_rsp_if import lpmf_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lpmf_cfg_if import lpmf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [VOL_W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: src/looping_pcm_mixer_with_fade_unit.sv
// Looping stereo sample player with linear fade-out.
// cmd: one operation per transfer (register slot, play slot, stop/fade, mix frame).
// rsp: exactly one result per cmd transfer, in order.
// cfg: volume write (256 = unity, larger values clamp to 256); write only when idle.
// Slot lengths and loop points sit in a small synchronous RAM read at the playing
// slot; slot valid bits are flops. Sample data lives outside: for each mix frame the
// caller supplies the song samples at the cursor reported in the previous result.
// Sequencing: register/play/stop and a mix while stopped go from exec straight to out;
// a mix without fade passes through scale and mix first, and a mix during a fade also
// passes through a multiply step and the 9-step restoring divider that forms
// volume * fade_left / fade_total, one quotient bit per cycle.
// A cmd is taken only in idle, so a new cmd waits until the last one has reached out.
// rsp is a registered output: a new cmd is taken while the last result waits, and
// the next result is held in the sequencer until rsp is free.
// Reset (arst_n low) empties all slots, stops playback, clears cursor and fade, and
// sets volume to unity. No clearing pass is needed.
module looping_pcm_mixer_with_fade_unit import lpmf_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	lpmf_cmd_if.sink   cmd,
	lpmf_rsp_if.source rsp,
	lpmf_cfg_if.sink   cfg
);

	state_t state_q, state_d;
	logic   in_rdy, out_load;

	cmd_t                    item_q;
	logic [VOL_W-1:0]        vol_q;
	logic [SLOT_COUNT-1:0]   slot_vld_q;
	logic                    playing_q;
	logic [7:0]              cur_slot_q;
	logic [FRAME_W-1:0]      cursor_q;
	logic [FRAME_W-1:0]      fade_total_q;
	logic [FRAME_W-1:0]      fade_left_q;

	slot_ent_t               slot_mem [SLOT_COUNT];
	slot_ent_t               rd_q;

	logic [NUM_W-1:0]        num_q;
	logic [NUM_W-1:0]        dsr_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [GAIN_W-1:0]       gain_q;
	logic signed [PROD_W-1:0] prod_l_q, prod_r_q;

	logic                    acc_q;
	logic signed [15:0]      ol_q, or_q;
	logic                    out_vld_q;
	rsp_t                    out_q;

	slot_lk_t                cmd_lk, cur_lk;
	logic                    mix_go;
	logic [FRAME_W-1:0]      frames, loop_pt, fade;
	logic                    div_ge;
	logic [FRAME_W:0]        cur_next;
	logic [FRAME_W-1:0]      left_next;
	logic signed [SUM_W-1:0] sum_l, sum_r;

	assign cmd_lk = slot_lookup(item_q.slot);
	assign cur_lk = slot_lookup(cur_slot_q);
	assign mix_go = playing_q && cur_lk.hit && slot_vld_q[cur_lk.idx];
	assign frames = item_q.song_frames[FRAME_W-1:0];
	assign loop_pt = item_q.loop_frame[FRAME_W-1:0];
	assign fade = item_q.fade_len[FRAME_W-1:0];
	assign div_ge = num_q >= dsr_q;
	assign cur_next = {1'b0, cursor_q} + (FRAME_W+1)'(1);
	assign left_next = (fade_left_q != '0) ? fade_left_q - FRAME_W'(1) : fade_left_q;
	assign sum_l = SUM_W'(item_q.mix_left) + SUM_W'(prod_l_q >>> GAIN_SHIFT);
	assign sum_r = SUM_W'(item_q.mix_right) + SUM_W'(prod_r_q >>> GAIN_SHIFT);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.valid)
					state_d = S_EXEC;
			end
			S_EXEC: begin
				if (item_q.operation == OP_MIX && mix_go)
					state_d = (fade_total_q != '0) ? S_MUL : S_SCALE;
				else
					state_d = S_OUT;
			end
			S_MUL:   state_d = S_DIV;
			S_DIV: begin
				if (cnt_q == '0)
					state_d = S_SCALE;
			end
			S_SCALE: state_d = S_MIX;
			S_MIX:   state_d = S_OUT;
			S_OUT: begin
				if (!out_vld_q || rsp.ready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_rdy = 1'b0;
		out_load = 1'b0;
		case (state_q)
			S_IDLE:  in_rdy = 1'b1;
			S_OUT:   out_load = !out_vld_q || rsp.ready;
			default: begin
				in_rdy = 1'b0;
				out_load = 1'b0;
			end
		endcase
	end

	assign cmd.ready = in_rdy;
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_vld_q;
	assign rsp.data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_q <= VOL_W'(VOL_UNITY);
		end else if (cfg.valid) begin
			vol_q <= (cfg.data > VOL_W'(VOL_UNITY)) ? VOL_W'(VOL_UNITY) : cfg.data;
		end
	end

	// slot table: one write port, one registered read at the playing slot
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC && item_q.operation == OP_REGISTER && cmd_lk.hit
				&& frames != '0) begin
			slot_mem[cmd_lk.idx] <= '{len: frames, loop: (loop_pt >= frames) ? '0 : loop_pt};
		end
		rd_q <= slot_mem[cur_lk.idx];
	end

	// playback state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_vld_q <= '0;
			playing_q <= 1'b0;
			cur_slot_q <= '0;
			cursor_q <= '0;
			fade_total_q <= '0;
			fade_left_q <= '0;
		end else if (state_q == S_EXEC) begin
			case (item_q.operation)
				OP_REGISTER: begin
					if (cmd_lk.hit && frames != '0)
						slot_vld_q[cmd_lk.idx] <= 1'b1;
				end
				OP_PLAY: begin
					if (cmd_lk.hit) begin
						if (!slot_vld_q[cmd_lk.idx]) begin
							playing_q <= 1'b0;
						end else begin
							playing_q <= 1'b1;
							cur_slot_q <= item_q.slot;
							cursor_q <= '0;
							fade_total_q <= '0;
							fade_left_q <= '0;
						end
					end
				end
				OP_STOP: begin
					if (playing_q) begin
						if (fade == '0)
							playing_q <= 1'b0;
						fade_total_q <= fade;
						fade_left_q <= fade;
					end
				end
				default: ;
			endcase
		end else if (state_q == S_MIX) begin
			if (fade_total_q != '0) begin
				fade_left_q <= left_next;
				if (left_next == '0)
					playing_q <= 1'b0;
			end
			if (cur_next >= {1'b0, rd_q.len})
				cursor_q <= rd_q.loop;
			else
				cursor_q <= cur_next[FRAME_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (in_rdy && cmd.valid)
			item_q <= cmd.data;
		case (state_q)
			S_EXEC: begin
				gain_q <= vol_q;
				case (item_q.operation)
					OP_REGISTER: begin
						acc_q <= cmd_lk.hit && frames != '0;
						ol_q <= '0;
						or_q <= '0;
					end
					OP_PLAY: begin
						acc_q <= cmd_lk.hit && slot_vld_q[cmd_lk.idx];
						ol_q <= '0;
						or_q <= '0;
					end
					OP_MIX: begin
						acc_q <= 1'b0;
						ol_q <= item_q.mix_left;
						or_q <= item_q.mix_right;
					end
					default: begin
						acc_q <= 1'b0;
						ol_q <= '0;
						or_q <= '0;
					end
				endcase
			end
			S_MUL: begin
				num_q <= NUM_W'(vol_q) * NUM_W'(fade_left_q);
				dsr_q <= NUM_W'(fade_total_q) << GAIN_SHIFT;
				cnt_q <= CNT_W'(GAIN_W - 1);
				gain_q <= '0;
			end
			S_DIV: begin
				// restoring division, one quotient bit per cycle, MSB first
				if (div_ge)
					num_q <= num_q - dsr_q;
				dsr_q <= dsr_q >> 1;
				gain_q <= {gain_q[GAIN_W-2:0], div_ge};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			S_SCALE: begin
				prod_l_q <= item_q.song_left * $signed({1'b0, gain_q});
				prod_r_q <= item_q.song_right * $signed({1'b0, gain_q});
			end
			S_MIX: begin
				ol_q <= sat16(sum_l);
				or_q <= sat16(sum_r);
				acc_q <= 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.accepted <= acc_q;
			out_q.out_left <= ol_q;
			out_q.out_right <= or_q;
			out_q.is_playing <= playing_q;
			out_q.active_slot <= playing_q ? cur_slot_q : '0;
			out_q.cursor <= 24'(cursor_q);
		end
	end

	a_play_slot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		playing_q |-> cur_lk.hit && slot_vld_q[cur_lk.idx])
		else $error("playing an unregistered slot");

	a_fade_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fade_left_q <= fade_total_q)
		else $error("fade_left above fade_total");

	a_gain_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCALE |-> gain_q <= vol_q)
		else $error("fade gain exceeds volume");

	a_cmd_starts_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> state_q == S_EXEC)
		else $error("cmd transfer did not start execution");

	a_rsp_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == S_OUT))
		else $error("result presented outside the output step");

endmodule
